@@ rtl/assert_macros.svh @@
// Assertion macros for the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SRTA_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("srta assertion failed");

// Check that an antecedent is followed by a consequent in the next cycle.
`define SRTA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("srta assertion failed");

`endif

@@ rtl/srta_pkg.sv @@
// Types, constants and helpers shared by the radix-to-ASCII converter.
`default_nettype none
package srta_pkg;

    localparam int RADIX_W  = 6;
    localparam int WIDTH_IN = 6;
    localparam int DIV_STEP = 8;    // quotient bits resolved per cycle

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PAD,
        S_SIGN,
        S_ZPAD,
        S_READ,
        S_DIGIT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic pad_calc;
        logic emit_sign;
        logic emit_pad;
        logic rd_digit;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic conv_done;
        logic neg;
        logic pad_zero;
        logic out_free;
        logic digit_last;
    } t_status;

    function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [7:0] c;
        begin
            if (d < 6'd10) begin
                c = CHAR_ZERO + {2'b00, d};
            end else if (d < RADIX_MAX) begin
                c = CHAR_A + {2'b00, d} - 8'd10;
            end else begin
                c = CHAR_ZERO;
            end
            return c;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/srta_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module srta_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/srta_ctrl.sv @@
// Sequencer for conversion: load, divide, pad, then emit characters.
`default_nettype none
module srta_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire srta_pkg::t_status i_status,
    output srta_pkg::t_cmd        o_cmd
);
    import srta_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.conv_done) begin
                    n_state = S_PAD;
                end
            end
            S_PAD: begin
                o_cmd.pad_calc = 1'b1;
                n_state        = i_status.neg ? S_SIGN : S_ZPAD;
            end
            S_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = S_ZPAD;
                end
            end
            S_ZPAD: begin
                if (i_status.pad_zero) begin
                    n_state = S_READ;
                end else if (i_status.out_free) begin
                    o_cmd.emit_pad = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.rd_digit = 1'b1;
                n_state        = S_DIGIT;
            end
            S_DIGIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    n_state          = i_status.digit_last ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/srta_datapath.sv @@
// Datapath: magnitude divider, digit store, padding count and output register.
`default_nettype none
`include "assert_macros.svh"
module srta_datapath #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_WIDTH  = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire srta_pkg::t_cmd               i_cmd,
    output srta_pkg::t_status                 o_status,
    input  wire logic [VALUE_BITS-1:0]        i_value,
    input  wire logic [srta_pkg::RADIX_W-1:0] i_radix,
    input  wire logic [srta_pkg::WIDTH_IN-1:0] i_min_width,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic [7:0]                        o_char,
    output logic                              o_last
);
    import srta_pkg::*;

    localparam int CHUNKS = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W  = CHUNKS * DIV_STEP;
    localparam int CH_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int SUM_W  = ((CNT_W > W_W) ? CNT_W : W_W) + 1;
    localparam int AW     = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam logic [WIDTH_IN-1:0] WIDTH_CAP = WIDTH_IN'(MAX_WIDTH);

    logic [DIV_W-1:0]   r_mag;
    logic [RADIX_W-1:0] r_rem;
    logic [RADIX_W-1:0] r_radix;
    logic [W_W-1:0]     r_width;
    logic               r_neg;
    logic [CNT_W-1:0]   r_dcount;
    logic [W_W-1:0]     r_pad;
    logic [CH_W-1:0]    r_chunk;
    logic               r_ovalid;
    logic [7:0]         r_char;
    logic               r_last;

    logic [DIV_W-1:0]    n_mag;
    logic [RADIX_W-1:0]  n_rem;
    logic [DIV_STEP-1:0] quot;
    logic [RADIX_W:0]    trial;
    logic [VALUE_BITS-1:0] neg_val;
    logic [W_W-1:0]      n_pad;
    logic [SUM_W-1:0]    used;
    logic [SUM_W-1:0]    wide;
    logic [CNT_W-1:0]    dcount_m1;
    logic [RADIX_W-1:0]  rd_digit;
    logic                chunk_last;
    logic                out_load;

    // Restoring division by the radix, one byte of the dividend per cycle.
    always_comb begin
        n_rem = r_rem;
        quot  = '0;
        trial = '0;
        for (int k = 0; k < DIV_STEP; k++) begin
            trial = {n_rem, r_mag[DIV_W-1-k]};
            if (trial >= {1'b0, r_radix}) begin
                n_rem               = RADIX_W'(trial - {1'b0, r_radix});
                quot[DIV_STEP-1-k]  = 1'b1;
            end else begin
                n_rem = trial[RADIX_W-1:0];
            end
        end
        n_mag = (r_mag << DIV_STEP) | DIV_W'(quot);
    end

    assign chunk_last = (r_chunk == CH_W'(CHUNKS - 1));
    assign neg_val    = '0 - i_value;
    assign dcount_m1  = r_dcount - 1'b1;

    always_comb begin
        used  = SUM_W'(r_dcount) + SUM_W'(r_neg);
        wide  = SUM_W'(r_width);
        n_pad = (used < wide) ? W_W'(wide - used) : '0;
    end

    assign out_load = i_cmd.emit_sign | i_cmd.emit_pad | i_cmd.emit_digit;

    srta_ram #(
        .WIDTH (RADIX_W),
        .DEPTH (VALUE_BITS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (i_cmd.div_step & chunk_last),
        .i_waddr (r_dcount[AW-1:0]),
        .i_wdata (n_rem),
        .i_re    (i_cmd.rd_digit),
        .i_raddr (dcount_m1[AW-1:0]),
        .o_rdata (rd_digit)
    );

    // Control counters and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcount <= '0;
            r_pad    <= '0;
            r_chunk  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_dcount <= '0;
                r_chunk  <= '0;
            end else if (i_cmd.div_step) begin
                if (chunk_last) begin
                    r_chunk  <= '0;
                    r_dcount <= r_dcount + 1'b1;
                end else begin
                    r_chunk <= r_chunk + 1'b1;
                end
            end else if (i_cmd.emit_digit) begin
                r_dcount <= dcount_m1;
            end
            if (i_cmd.pad_calc) begin
                r_pad <= n_pad;
            end else if (i_cmd.emit_pad) begin
                r_pad <= r_pad - 1'b1;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[VALUE_BITS-1];
            r_mag <= DIV_W'(i_value[VALUE_BITS-1] ? neg_val : i_value);
            r_rem <= '0;
            if (i_radix < RADIX_MIN) begin
                r_radix <= RADIX_MIN;
            end else if (i_radix > RADIX_MAX) begin
                r_radix <= RADIX_MAX;
            end else begin
                r_radix <= i_radix;
            end
            r_width <= W_W'((i_min_width > WIDTH_CAP) ? WIDTH_CAP : i_min_width);
        end else if (i_cmd.div_step) begin
            r_mag <= n_mag;
            r_rem <= chunk_last ? '0 : n_rem;
        end
        if (out_load) begin
            if (i_cmd.emit_sign) begin
                r_char <= CHAR_MINUS;
            end else if (i_cmd.emit_pad) begin
                r_char <= CHAR_ZERO;
            end else begin
                r_char <= digit_char(rd_digit);
            end
            r_last <= i_cmd.emit_digit & (r_dcount == CNT_W'(1));
        end
    end

    always_comb begin
        o_status.conv_done  = i_cmd.div_step & chunk_last &
                              ((n_mag == '0) || (r_dcount == CNT_W'(VALUE_BITS - 1)));
        o_status.neg        = r_neg;
        o_status.pad_zero   = (r_pad == '0);
        o_status.out_free   = !r_ovalid || i_out_ready;
        o_status.digit_last = (r_dcount == CNT_W'(1));
    end

    assign o_out_valid = r_ovalid;
    assign o_char      = r_char;
    assign o_last      = r_last;

    `SRTA_ASSERT(a_rem_below_radix, !i_cmd.div_step || (r_rem < r_radix))
    `SRTA_ASSERT(a_no_overwrite, !out_load || !r_ovalid || i_out_ready)
    `SRTA_ASSERT(a_pad_no_underflow, !i_cmd.emit_pad || (r_pad != '0))
    `SRTA_ASSERT_NEXT(a_last_ends_run, out_load && i_cmd.emit_digit && (r_dcount == CNT_W'(1)),
                      r_ovalid && r_last && (r_dcount == '0))

endmodule
`default_nettype wire

@@ rtl/signed_radix_to_ascii_top.sv @@
// Top level of the signed integer to ASCII text converter.
`default_nettype none
// Converts one signed value per input beat into its text in a radix of 2 to
// 36, most significant character first, one character per output beat, with
// tlast on the final character. A negative value starts with '-', the sign
// counts toward the minimum width and zeros pad the digits up to it; digits
// above 9 are lower-case letters. A radix outside 2..36 and a width above
// MAX_WIDTH saturate. Each digit comes from the restoring divider, which
// works through the magnitude a byte at a time and resolves eight quotient
// bits a cycle; digits go to a small RAM and are read back in reverse
// through its registered read, with a read state ahead of each character.
// The next input beat is taken once the last character sits in the output
// register, while that character still waits to be taken.
module signed_radix_to_ascii_top #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_WIDTH  = 32,
    localparam int IN_W = ((VALUE_BITS + 2 * 6 + 7) / 8) * 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    // value [VALUE_BITS-1:0], radix [6], min_width [6], zero fill
    input  wire logic [IN_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    // char_code [7:0]
    output logic [7:0]           m_axis_tdata,
    output logic                 m_axis_tlast
);
    import srta_pkg::*;

    t_cmd    cmd;
    t_status status;

    srta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    srta_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_value     (s_axis_tdata[VALUE_BITS-1:0]),
        .i_radix     (s_axis_tdata[VALUE_BITS +: RADIX_W]),
        .i_min_width (s_axis_tdata[VALUE_BITS + RADIX_W +: WIDTH_IN]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_char      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule
`default_nettype wire
